/* rtl/core/bshe_pkg.sv */
// Package: shared types, opcodes and hash constants for the byte stream hash engine.
`default_nettype none
package bshe_pkg;

  localparam logic [1:0] MODE_DJB2 = 2'd0;
  localparam logic [1:0] MODE_FNV  = 2'd1;
  localparam logic [1:0] MODE_MUR  = 2'd2;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;
  localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2    = 32'h1b873593;
  localparam logic [31:0] MUR_N     = 32'he6546b64;
  localparam logic [31:0] MUR_F1    = 32'h85ebca6b;
  localparam logic [31:0] MUR_F2    = 32'hc2b2ae35;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_SEED = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_BYTE = 4'd1,
    OP_K1   = 4'd2,
    OP_K2   = 4'd3,
    OP_MIX  = 4'd4,
    OP_TXOR = 4'd5,
    OP_F0   = 4'd6,
    OP_F1   = 4'd7,
    OP_F2   = 4'd8,
    OP_OUT  = 4'd9
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] lane;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/core/bshe_ctrl.sv */
// Controller: sequences byte steps, Murmur word mixing, finalization and output load.
`default_nettype none
module bshe_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire                  in_tlast,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  wire bshe_pkg::stat_t stat,
  output bshe_pkg::cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_K1   = 11'b000_0000_0010,
    S_K2   = 11'b000_0000_0100,
    S_MIX  = 11'b000_0000_1000,
    S_T1   = 11'b000_0001_0000,
    S_T2   = 11'b000_0010_0000,
    S_TX   = 11'b000_0100_0000,
    S_F0   = 11'b000_1000_0000,
    S_F1   = 11'b001_0000_0000,
    S_F2   = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   accept;
  logic   load;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign load       = (state_r == S_OUT) && (!ovalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd.op    = bshe_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op   = bshe_pkg::OP_BYTE;
          last_nxt = in_tlast;
          if (stat.mode == bshe_pkg::MODE_MUR && stat.lane == 2'd3) begin
            state_nxt = S_K1;
          end else if (in_tlast) begin
            state_nxt = (stat.mode == bshe_pkg::MODE_MUR) ? S_T1 : S_OUT;
          end
        end
      end
      S_K1: begin
        cmd.op    = bshe_pkg::OP_K1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.op    = bshe_pkg::OP_K2;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.op    = bshe_pkg::OP_MIX;
        state_nxt = last_r ? S_F0 : S_IDLE;
      end
      S_T1: begin
        cmd.op    = bshe_pkg::OP_K1;
        state_nxt = S_T2;
      end
      S_T2: begin
        cmd.op    = bshe_pkg::OP_K2;
        state_nxt = S_TX;
      end
      S_TX: begin
        cmd.op    = bshe_pkg::OP_TXOR;
        state_nxt = S_F0;
      end
      S_F0: begin
        cmd.op    = bshe_pkg::OP_F0;
        state_nxt = S_F1;
      end
      S_F1: begin
        cmd.op    = bshe_pkg::OP_F1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.op    = bshe_pkg::OP_F2;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          cmd.op    = bshe_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (load) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      last_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      last_r   <= last_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bshe_datapath.sv */
// Datapath: config registers, hash state, shared multiplier and output register.
`default_nettype none
module bshe_datapath (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire                  cfg_index,
  input  wire  [31:0]          cfg_wdata,
  input  wire  [7:0]           data_byte,
  input  wire bshe_pkg::cmd_t  cmd,
  output bshe_pkg::stat_t      stat,
  output logic [31:0]          hash_value
);

  logic [1:0]  mode_r;
  logic [31:0] seed_r;
  logic        open_r, open_nxt;
  logic [1:0]  kmode_r, kmode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] gath_r, gath_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] out_r, out_nxt;

  logic [1:0]  mode_eff;
  logic [31:0] h_base;
  logic [31:0] cnt_base;
  logic [31:0] gath_base;
  logic [1:0]  lane;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] krot, mix_x, mix_r, fin_x, f2_a;

  assign mode_eff  = open_r ? kmode_r : mode_r;
  assign h_base    = open_r ? acc_r :
                     ((mode_r == bshe_pkg::MODE_FNV) ? (seed_r ^ bshe_pkg::FNV_BASIS) : seed_r);
  assign cnt_base  = open_r ? cnt_r : 32'd0;
  assign gath_base = open_r ? gath_r : 32'd0;
  assign lane      = cnt_base[1:0];

  assign stat.mode = mode_eff;
  assign stat.lane = lane;

  assign krot  = {k_r[16:0], k_r[31:17]};
  assign mix_x = acc_r ^ k_r;
  assign mix_r = {mix_x[18:0], mix_x[31:19]};
  assign fin_x = acc_r ^ cnt_r;
  assign f2_a  = acc_r ^ {13'd0, acc_r[31:13]};

  always_comb begin
    mul_a = h_base ^ {24'd0, data_byte};
    mul_b = bshe_pkg::FNV_PRIME;
    case (cmd.op)
      bshe_pkg::OP_K1: begin
        mul_a = gath_r;
        mul_b = bshe_pkg::MUR_C1;
      end
      bshe_pkg::OP_K2: begin
        mul_a = krot;
        mul_b = bshe_pkg::MUR_C2;
      end
      bshe_pkg::OP_F1: begin
        mul_a = acc_r;
        mul_b = bshe_pkg::MUR_F1;
      end
      bshe_pkg::OP_F2: begin
        mul_a = f2_a;
        mul_b = bshe_pkg::MUR_F2;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    open_nxt  = open_r;
    kmode_nxt = kmode_r;
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    gath_nxt  = gath_r;
    cnt_nxt   = cnt_r;
    out_nxt   = out_r;
    unique case (cmd.op)
      bshe_pkg::OP_NONE: begin
      end
      bshe_pkg::OP_BYTE: begin
        open_nxt  = 1'b1;
        kmode_nxt = mode_eff;
        cnt_nxt   = cnt_base + 32'd1;
        gath_nxt  = gath_base | ({24'd0, data_byte} << {lane, 3'b000});
        case (mode_eff)
          bshe_pkg::MODE_FNV: acc_nxt = mul_p;
          bshe_pkg::MODE_MUR: acc_nxt = h_base;
          default:            acc_nxt = {h_base[26:0], 5'd0} + h_base + {24'd0, data_byte};
        endcase
      end
      bshe_pkg::OP_K1: begin
        k_nxt = mul_p;
      end
      bshe_pkg::OP_K2: begin
        k_nxt = mul_p;
      end
      bshe_pkg::OP_MIX: begin
        acc_nxt  = {mix_r[29:0], 2'b00} + mix_r + bshe_pkg::MUR_N;
        gath_nxt = 32'd0;
      end
      bshe_pkg::OP_TXOR: begin
        acc_nxt = acc_r ^ k_r;
      end
      bshe_pkg::OP_F0: begin
        acc_nxt = fin_x ^ {16'd0, fin_x[31:16]};
      end
      bshe_pkg::OP_F1: begin
        acc_nxt = mul_p;
      end
      bshe_pkg::OP_F2: begin
        acc_nxt = mul_p;
      end
      bshe_pkg::OP_OUT: begin
        open_nxt = 1'b0;
        out_nxt  = (kmode_r == bshe_pkg::MODE_MUR) ? (acc_r ^ {16'd0, acc_r[31:16]}) : acc_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bshe_pkg::MODE_DJB2;
      seed_r  <= 32'd0;
      open_r  <= 1'b0;
      kmode_r <= bshe_pkg::MODE_DJB2;
    end else begin
      open_r  <= open_nxt;
      kmode_r <= kmode_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          bshe_pkg::REG_MODE: mode_r <= cfg_wdata[1:0];
          bshe_pkg::REG_SEED: seed_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    k_r    <= k_nxt;
    gath_r <= gath_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

  assign hash_value = out_r;

endmodule
`default_nettype wire

/* rtl/core/byte_stream_hash_engine.sv */
// Top level: byte stream hash engine (djb2, FNV-1a 32, MurmurHash3 x86 32).
//
//  channel | dir | handshake         | payload
//  in_     | in  | tvalid/tready     | tdata[7:0] data_byte, tlast last_byte
//  out_    | out | tvalid/tready     | tdata[31:0] hash_value
//  cfg_    | in  | wr_en             | index 0 hash_mode, 1 hash_seed; wdata[31:0]
//
// djb2 and FNV bytes are taken back to back; a Murmur byte that completes a word is
// followed by three steps (through the shared 32x32 multiplier and the mix adder).
// After the last byte Murmur runs the tail scramble (if a word is partial) and fmix.
// Reset is synchronous, active low; the hash state needs no clearing pass.
// A result waits in the output register; a new key streams in meanwhile and
// stalls only when its own result is ready before the previous one is taken.
`default_nettype none
module byte_stream_hash_engine (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] hash_value
  input  wire         cfg_wr_en,
  input  wire         cfg_index,
  input  wire  [31:0] cfg_wdata
);

  bshe_pkg::cmd_t  cmd;
  bshe_pkg::stat_t stat;

  bshe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bshe_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .data_byte  (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .hash_value (out_tdata)
  );

endmodule
`default_nettype wire
